>>> design/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

    localparam int IDX_W         = 5;
    localparam int SIZE_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int NUM_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0]  CFG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_BLOCKS_IN_USE = 2'd1;
    localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 6'd32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2,
        MODE_NEXT  = 2'd3
    } t_fit_mode;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  load_index;
        logic [SIZE_W-1:0] size_value;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  chosen_index;
        logic [SIZE_W-1:0] left_after;
    } t_rsp;

endpackage

`default_nettype wire

>>> design/fit_policy_partition_allocator.sv
`default_nettype none

// Fit-policy block allocator. A load request writes one entry of the size table and
// produces no response. An allocate request scans the table, which lives in a ring of
// cells that rotates once past a single compare unit at cell 0, one entry per cycle;
// once the output register is free, a final step writes the reduced size back and
// loads the response register. One request is in work at a time; a finished response
// may wait in the output register while the next request is taken.
// The policy and the searched count come from two write-only registers: index 0 is
// fit_mode (first, best, worst, next fit) and index 1 is blocks_in_use.

module fit_policy_partition_allocator
    import fpa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_req                  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_rsp                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int CW  = (IW + 1 > CFG_DATA_W) ? IW + 1 : CFG_DATA_W;
    localparam int LIW = (IW > IDX_W) ? IW : IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state               r_state;
    t_fit_mode            r_mode, r_op_mode;
    logic [CFG_DATA_W-1:0] r_blocks;
    logic [IW-1:0]        r_ptr, r_cnt, r_start;
    logic [CW-1:0]        r_limit;
    logic [SIZE_BITS-1:0] r_req;
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic [SIZE_BITS-1:0] w_cell [NUM_BLOCKS];
    logic                 w_in_acc, w_out_free, w_finish, w_commit, w_load;
    logic                 w_wr;
    logic [LIW-1:0]       w_wr_idx;
    logic [SIZE_BITS-1:0] w_wr_data, w_left, w_in_size;
    logic [CW-1:0]        w_m;
    logic [IW-1:0]        w_start;
    logic                 w_in_range, w_shift;
    logic                 w_found;
    logic [IW-1:0]        w_pick;
    logic [SIZE_BITS-1:0] w_pick_val;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == ST_DONE) && w_out_free;
    assign w_commit   = w_finish && w_found;
    assign w_load     = w_in_acc && (i_in_data.cmd == CMD_LOAD);
    assign w_in_size  = SIZE_BITS'(i_in_data.size_value);
    assign w_left     = w_pick_val - r_req;
    assign w_shift    = (r_state == ST_SCAN);
    assign w_in_range = (CW'(r_cnt) < r_limit);

    assign w_m     = (CW'(r_blocks) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(r_blocks);
    assign w_start = (CW'(r_ptr) < w_m) ? r_ptr : '0;

    always_comb begin
        w_wr      = w_load || w_commit;
        w_wr_idx  = w_load ? LIW'(i_in_data.load_index) : LIW'(w_pick);
        w_wr_data = w_load ? w_in_size : w_left;
    end

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_ring
        fpa_cell #(
            .SIZE_BITS(SIZE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_shift_data(w_cell[(g + 1) % NUM_BLOCKS]),
            .i_wr        (w_wr && (w_wr_idx == LIW'(g))),
            .i_wr_data   (w_wr_data),
            .o_value     (w_cell[g])
        );
    end

    fpa_select #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_select (
        .i_clk     (i_clk),
        .i_clr     (w_in_acc && (i_in_data.cmd == CMD_ALLOC)),
        .i_en      (w_shift),
        .i_mode    (r_op_mode),
        .i_idx     (r_cnt),
        .i_value   (w_cell[0]),
        .i_in_range(w_in_range),
        .i_req     (r_req),
        .i_start   (r_start),
        .o_found   (w_found),
        .o_idx     (w_pick),
        .o_value   (w_pick_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_FIRST;
            r_op_mode   <= MODE_FIRST;
            r_blocks    <= BLOCKS_IN_USE_RST;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIT_MODE:      r_mode   <= t_fit_mode'(i_cfg_data[1:0]);
                    CFG_BLOCKS_IN_USE: r_blocks <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.cmd == CMD_LOAD) begin
                            r_ptr <= '0;
                        end else begin
                            r_req     <= w_in_size;
                            r_op_mode <= r_mode;
                            r_start   <= w_start;
                            r_limit   <= w_m;
                            r_cnt     <= '0;
                            r_state   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(NUM_BLOCKS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        r_out.granted      <= w_found;
                        r_out.chosen_index <= w_found ? IDX_W'(w_pick) : '0;
                        r_out.left_after   <= w_found ? SIZE_W'(w_left) : '0;
                        if (w_found && (r_op_mode == MODE_NEXT)) begin
                            r_ptr <= w_pick;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> design/fpa_cell.sv
`default_nettype none

module fpa_cell
    import fpa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_shift,
    input  wire logic [SIZE_BITS-1:0] i_shift_data,
    input  wire logic                 i_wr,
    input  wire logic [SIZE_BITS-1:0] i_wr_data,
    output logic      [SIZE_BITS-1:0] o_value
);

    logic [SIZE_BITS-1:0] r_value;
    logic [SIZE_BITS-1:0] n_value;

    always_comb begin
        if (i_wr) begin
            n_value = i_wr_data;
        end else if (i_shift) begin
            n_value = i_shift_data;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

>>> design/fpa_select.sv
`default_nettype none

module fpa_select
    import fpa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_clr,
    input  wire logic                          i_en,
    input  wire t_fit_mode                     i_mode,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0] i_idx,
    input  wire logic [SIZE_BITS-1:0]          i_value,
    input  wire logic                          i_in_range,
    input  wire logic [SIZE_BITS-1:0]          i_req,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0] i_start,
    output logic                               o_found,
    output logic      [$clog2(NUM_BLOCKS)-1:0] o_idx,
    output logic      [SIZE_BITS-1:0]          o_value
);

    localparam int IW = $clog2(NUM_BLOCKS);

    // a: entries at or above the start point (all entries unless next fit)
    // b: wrapped part of a next-fit search
    logic                 r_found_a, r_found_b;
    logic [IW-1:0]        r_idx_a, r_idx_b;
    logic [SIZE_BITS-1:0] r_val_a, r_val_b;

    logic w_fit, w_hi, w_take_a, w_take_b;

    always_comb begin
        w_fit    = i_en && i_in_range && (i_value >= i_req);
        w_hi     = (i_mode != MODE_NEXT) || (i_idx >= i_start);
        w_take_b = w_fit && !w_hi && !r_found_b;
        w_take_a = 1'b0;
        if (w_fit && w_hi) begin
            case (i_mode)
                MODE_BEST:  w_take_a = !r_found_a || (i_value < r_val_a);
                MODE_WORST: w_take_a = !r_found_a || (i_value > r_val_a);
                default:    w_take_a = !r_found_a;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
        end else begin
            if (w_take_a) begin
                r_found_a <= 1'b1;
                r_idx_a   <= i_idx;
                r_val_a   <= i_value;
            end
            if (w_take_b) begin
                r_found_b <= 1'b1;
                r_idx_b   <= i_idx;
                r_val_b   <= i_value;
            end
        end
    end

    assign o_found = r_found_a || r_found_b;
    assign o_idx   = r_found_a ? r_idx_a : r_idx_b;
    assign o_value = r_found_a ? r_val_a : r_val_b;

endmodule

`default_nettype wire

>>> design/fpa_checker.sv
`default_nettype none

module fpa_checker
    import fpa_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_req                  i_in_data,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_rsp                  o_out_data,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled response changed");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.granted |->
            o_out_data.chosen_index == '0 && o_out_data.left_after == '0)
        else $error("refused response carries data");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_data.cmd == CMD_LOAD && !o_out_valid |=> !o_out_valid)
        else $error("load produced a response");

    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_data.cmd == CMD_ALLOC |=> o_in_stall && !$rose(o_out_valid))
        else $error("allocate did not start a search");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (.*);

`default_nettype wire

>>> dv/fit_policy_partition_allocator_tb.sv
`default_nettype none

module fit_policy_partition_allocator_tb;
    import fpa_pkg::*;

    localparam int SETTLE_CYCLES = NUM_BLOCKS_DEF + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 12;

    class alloc_tracker;
        logic [SIZE_W-1:0]     sizes [NUM_BLOCKS_DEF];
        logic [IDX_W-1:0]      nf_ptr;
        t_fit_mode             mode;
        logic [CFG_DATA_W-1:0] span;
        t_rsp                  grant_q [$];
        int                    fail_count;
        int                    shown;

        function new();
            foreach (sizes[i]) sizes[i] = '0;
            nf_ptr     = '0;
            mode       = MODE_FIRST;
            span       = BLOCKS_IN_USE_RST;
            fail_count = 0;
            shown      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FIT_MODE) begin
                mode = t_fit_mode'(val[1:0]);
            end else if (idx == CFG_BLOCKS_IN_USE) begin
                span = val;
            end
        endfunction

        function int pending();
            return grant_q.size();
        endfunction

        function void note_request(t_req r);
            t_rsp g;
            int   lim;
            int   start;
            int   j;
            int   pick;
            bit   hit;
            if (r.cmd == CMD_LOAD) begin
                sizes[r.load_index] = r.size_value;
                nf_ptr = '0;
            end else begin
                lim  = (span > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(span);
                hit  = 1'b0;
                pick = 0;
                if (mode == MODE_NEXT) begin
                    start = (nf_ptr < lim) ? int'(nf_ptr) : 0;
                    for (int k = 0; k < lim && !hit; k++) begin
                        j = (start + k) % lim;
                        if (sizes[j] >= r.size_value) begin
                            hit  = 1'b1;
                            pick = j;
                        end
                    end
                end else begin
                    for (int k = 0; k < lim && !(hit && mode == MODE_FIRST); k++) begin
                        if (sizes[k] >= r.size_value) begin
                            if (!hit) begin
                                hit  = 1'b1;
                                pick = k;
                            end else if (mode == MODE_BEST && sizes[k] < sizes[pick]) begin
                                pick = k;
                            end else if (mode == MODE_WORST && sizes[k] > sizes[pick]) begin
                                pick = k;
                            end
                        end
                    end
                end
                g = '0;
                if (hit) begin
                    sizes[pick] = sizes[pick] - r.size_value;
                    if (mode == MODE_NEXT) begin
                        nf_ptr = IDX_W'(pick);
                    end
                    g.granted      = 1'b1;
                    g.chosen_index = IDX_W'(pick);
                    g.left_after   = sizes[pick];
                end
                grant_q.push_back(g);
            end
        endfunction

        function void check_grant(t_rsp got);
            t_rsp want;
            if (grant_q.size() == 0) begin
                fail_count++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected response: g=%0d idx=%0d left=%0h",
                             got.granted, got.chosen_index, got.left_after);
                end
            end else begin
                want = grant_q.pop_front();
                if (got.granted !== want.granted || got.chosen_index !== want.chosen_index
                        || got.left_after !== want.left_after) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("response error: exp g=%0d idx=%0d left=%0h, got g=%0d idx=%0d left=%0h",
                                 want.granted, want.chosen_index, want.left_after,
                                 got.granted, got.chosen_index, got.left_after);
                    end
                end
            end
        endfunction

        function void check_drained();
            if (grant_q.size() != 0) begin
                fail_count += grant_q.size();
                if (shown < 10) begin
                    $display("%0d responses never arrived", grant_q.size());
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_req                  in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_rsp                  out_data;

    bit                    quiet        = 1'b0;
    bit                    hold_request = 1'b0;
    alloc_tracker          tracker;

    fit_policy_partition_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req load_req(int idx, logic [SIZE_W-1:0] sz);
        t_req r;
        r.cmd        = CMD_LOAD;
        r.load_index = IDX_W'(idx);
        r.size_value = sz;
        return r;
    endfunction

    function automatic t_req alloc_req(logic [SIZE_W-1:0] sz);
        t_req r;
        r.cmd        = CMD_ALLOC;
        r.load_index = IDX_W'($urandom_range(0, NUM_BLOCKS_DEF - 1));
        r.size_value = sz;
        return r;
    endfunction

    task automatic send_request(input t_req r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = r;
        do @(posedge clk); while (in_stall);
        tracker.note_request(r);
    endtask

    // drop valid, wait for all responses, then let any trailing load finish
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic set_mode(input t_fit_mode m);
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(m));
    endtask

    task automatic directed();
        logic [SIZE_W-1:0] v;
        for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
            case (i)
                0:          v = '0;
                1, 30, 31:  v = 16'hFFFF;
                2:          v = 16'hAAAA;
                3:          v = 16'h5555;
                5, 6:       v = 16'h0200;
                default:    v = SIZE_W'($urandom_range(16'h0100, 16'h0FFF));
            endcase
            send_request(load_req(i, v));
        end
        send_request(alloc_req(16'h0000));
        send_request(alloc_req(16'hFFFF));
        send_request(alloc_req(16'hFFFF));
        settle();
        set_mode(MODE_NEXT);
        send_request(alloc_req(16'h8000));
        send_request(alloc_req(16'hF000));
        send_request(alloc_req(16'h0000));
        send_request(alloc_req(16'h5000));
        settle();
        // pointer now sits past the searched range
        write_reg(CFG_BLOCKS_IN_USE, 6'd2);
        send_request(alloc_req(16'h0000));
        settle();
        write_reg(CFG_BLOCKS_IN_USE, 6'd32);
        send_request(load_req(7, 16'h0040));
        send_request(alloc_req(16'h0030));
        settle();
        write_reg(CFG_BLOCKS_IN_USE, 6'd0);
        send_request(alloc_req(16'h0000));
        settle();
        write_reg(CFG_BLOCKS_IN_USE, 6'd63);
        send_request(alloc_req(16'hFFFF));
        send_request(alloc_req(16'h0001));
        settle();
        write_reg(CFG_BLOCKS_IN_USE, 6'd32);
        set_mode(MODE_BEST);
        send_request(alloc_req(16'h0200));
        send_request(alloc_req(16'h0001));
        settle();
        set_mode(MODE_WORST);
        send_request(alloc_req(16'h0010));
        send_request(alloc_req(16'h0010));
    endtask

    task automatic random_item();
        int                roll;
        logic [SIZE_W-1:0] sz;
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      sz = SIZE_W'($urandom_range(0, 1023));
            else if (roll < 85) sz = SIZE_W'($urandom_range(0, 65535));
            else if (roll < 93) sz = 16'hFFFF;
            else                sz = '0;
            send_request(load_req($urandom_range(0, NUM_BLOCKS_DEF - 1), sz));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10)      sz = '0;
            else if (roll < 40) sz = tracker.sizes[$urandom_range(0, NUM_BLOCKS_DEF - 1)];
            else if (roll < 80) sz = SIZE_W'($urandom_range(0, 300));
            else                sz = SIZE_W'($urandom_range(0, 65535));
            send_request(alloc_req(sz));
        end
    endtask

    initial begin : rx_stall
        int n;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
                out_stall    = 1'b0;
            end else begin
                n = pick_gap();
                out_stall = (n > 0);
                if (n > 1) begin
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            tracker.check_grant(out_data);
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] span;
        int                    count;
        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_mode(MODE_FIRST);
        write_reg(CFG_BLOCKS_IN_USE, BLOCKS_IN_USE_RST);
        directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p % 6)
                0:       span = 6'd32;
                1:       span = CFG_DATA_W'($urandom_range(2, 31));
                2:       span = 6'd1;
                3:       span = 6'd63;
                4:       span = 6'd0;
                default: span = 6'd33;
            endcase
            set_mode(t_fit_mode'(p % 4));
            write_reg(CFG_BLOCKS_IN_USE, span);
            quiet = (p == 4 || p == 9);
            count = (span == 0) ? 25 : 95;
            for (int i = 0; i < count; i++) begin
                if (p == 1 && i == 30) begin
                    hold_request = 1'b1;
                end
                if (p == 7 && i == 40) begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    while (tracker.pending() != 0) @(posedge clk);
                end
                random_item();
            end
        end
        quiet = 1'b0;
        settle();
        tracker.check_drained();
        if (tracker.fail_count == 0) begin
            $display("fit_policy_partition_allocator: match");
        end else begin
            $display("fit_policy_partition_allocator: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #16_000_000;
        $display("fit_policy_partition_allocator: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/fpa_pkg.sv
design/fpa_cell.sv
design/fpa_select.sv
design/fit_policy_partition_allocator.sv
design/fpa_checker.sv
dv/fit_policy_partition_allocator_tb.sv
